// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/ftwa_pkg.sv -----
// Types, constants and helpers of the flow table.
package ftwa_pkg;
  localparam int BUCKETS = 64;
  localparam int WAYS    = 4;
  localparam int BKT_W   = $clog2(BUCKETS);
  localparam int WAY_W   = $clog2(WAYS);
  localparam int REM_W   = 10;

  localparam logic [31:0] HASH_MUL    = 32'd59;
  localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;
  localparam logic [8:0]  REMOVED_MAX = 9'd511;

  localparam logic [1:0] REG_TRACE_GAP      = 2'd0;
  localparam logic [1:0] REG_SWEEP_INTERVAL = 2'd1;
  localparam logic [1:0] REG_IDLE_LIMIT     = 2'd2;
  localparam logic [1:0] REG_MIN_PACKETS    = 2'd3;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] ports;
    logic [7:0]  protocol;
    logic [31:0] count;
    logic [31:0] last_time;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic             hit;
    logic             dropped;
    logic [WAY_W-1:0] way;
    logic [31:0]      packets;
  } match_t;

  // now - then > lim, with a backward step never exceeding the limit
  function automatic logic elapsed_gt(logic [31:0] now, logic [31:0] then,
                                      logic [31:0] lim);
    return (now > then) && ((now - then) > lim);
  endfunction
endpackage

// ----- hw/rtl/ftwa_if.sv -----
// Valid/ready channels for packet tuples and lookup results.
interface ftwa_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [7:0]  protocol;
  logic [31:0] time_sec;
  modport source (output valid, src_addr, dst_addr, src_port, dst_port, protocol,
                  time_sec, input ready);
  modport sink (input valid, src_addr, dst_addr, src_port, dst_port, protocol,
                time_sec, output ready);
endinterface

interface ftwa_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        dropped;
  logic [5:0]  bucket;
  logic [1:0]  way;
  logic [31:0] flow_packets;
  logic        new_trace;
  logic [15:0] trace_number;
  logic        swept;
  logic [8:0]  removed;
  modport source (output valid, hit, dropped, bucket, way, flow_packets, new_trace,
                  trace_number, swept, removed, input ready);
  modport sink (input valid, hit, dropped, bucket, way, flow_packets, new_trace,
                trace_number, swept, removed, output ready);
endinterface

// ----- hw/rtl/ftwa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ftwa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- hw/rtl/ftwa_match.sv -----
// Bucket way compare, count update and insert of one packet.
module ftwa_match (
  input  ftwa_pkg::row_t                row,
  input  logic [ftwa_pkg::WAYS-1:0]     vld,
  input  logic [31:0]                   src_addr,
  input  logic [31:0]                   dst_addr,
  input  logic [31:0]                   ports,
  input  logic [7:0]                    protocol,
  input  logic [31:0]                   now,
  output ftwa_pkg::match_t              res,
  output ftwa_pkg::row_t                row_new,
  output logic [ftwa_pkg::WAYS-1:0]     vld_new,
  output logic                          wr
);
  import ftwa_pkg::*;

  logic [WAYS-1:0]  mvec;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] free_way;
  logic [31:0]      cnt;

  always_comb begin
    hit_way  = '0;
    free_way = '0;
    res      = '0;
    row_new  = row;
    vld_new  = vld;
    cnt      = '0;
    for (int w = 0; w < WAYS; w++) begin
      mvec[w] = vld[w] && row[w].src_addr == src_addr && row[w].dst_addr == dst_addr &&
                row[w].ports == ports && row[w].protocol == protocol;
    end
    // lowest way wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (mvec[w]) hit_way = WAY_W'(w);
      if (!vld[w]) free_way = WAY_W'(w);
    end
    if (|mvec) begin
      cnt = row[hit_way].count;
      if (cnt != COUNT_MAX) cnt = cnt + 32'd1;
      row_new[hit_way].count     = cnt;
      row_new[hit_way].last_time = now;
      res.hit     = 1'b1;
      res.way     = hit_way;
      res.packets = cnt;
    end else if (!(&vld)) begin
      row_new[free_way] = '{src_addr: src_addr, dst_addr: dst_addr, ports: ports,
                            protocol: protocol, count: 32'd1, last_time: now};
      vld_new[free_way] = 1'b1;
      res.way     = free_way;
      res.packets = 32'd1;
    end else begin
      res.dropped = 1'b1;
    end
    wr = !res.dropped;
  end
endmodule

// ----- hw/rtl/flow_table_with_aging_top.sv -----
// Flow table top level: sequencer, config registers, valid bits and result register.
// Takes one packet tuple at a time. A plain packet steps through accept,
// bucket row read, compare and write back, and result load. A packet that
// starts a new trace, and one that triggers an aging sweep, each add a pass
// over all BUCKETS bucket rows: the sweep reads the flow RAM one bucket row
// per cycle, clears valid bits of evicted ways in the cycle after each row
// read, and then exits. Valid bits live in flip-flops, so no clearing pass
// runs after reset. A finished result waits in the output register while
// the next packet is taken; a result that finds the output register still
// full holds in the last state until the sink takes the waiting beat.
`include "assert_macros.svh"
module flow_table_with_aging_top (
  input  logic        clk,
  input  logic        rst_n,
  ftwa_in_if.sink     in_ch,
  ftwa_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_data
);
  import ftwa_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SPLIT, S_LOOK, S_CMP, S_SWEEP, S_DONE} state_t;

  state_t state_r;

  logic [31:0] trace_gap_r, interval_r, idle_r, min_r;
  logic [31:0] t_src_r, t_dst_r, t_ports_r, t_time_r;
  logic [7:0]  t_proto_r;
  logic [31:0] prev_r, anchor_r;
  logic        seen_r;
  logic [15:0] trace_r;
  logic [BUCKETS-1:0][WAYS-1:0] valid_r;
  logic [BKT_W:0]   scan_r;
  logic             pend_r;
  logic [BKT_W-1:0] prow_r;
  logic             aging_r;
  logic [REM_W-1:0] removed_r;
  logic             new_trace_r, swept_r;
  match_t           res_r;
  logic [BKT_W-1:0] bucket_r;

  logic             out_valid_r, o_hit_r, o_drop_r, o_new_r, o_swept_r;
  logic [5:0]       o_bucket_r;
  logic [1:0]       o_way_r;
  logic [31:0]      o_pk_r;
  logic [15:0]      o_trace_r;
  logic [8:0]       o_rem_r;

  logic [31:0]      prod, hash32;
  logic [BKT_W-1:0] bucket_c, raddr;
  logic             re, scan_re, scan_end;
  logic [ROW_W-1:0] rd_data;
  row_t             row_rd, row_new;
  logic [WAYS-1:0]  ev, vld_new;
  match_t           mres;
  logic             mwr;

  assign prod     = t_src_r * HASH_MUL;
  assign hash32   = prod ^ t_dst_r ^ t_ports_r ^ {24'd0, t_proto_r};
  assign bucket_c = hash32[BKT_W-1:0];
  assign row_rd   = row_t'(rd_data);
  assign scan_re  = scan_r < (BKT_W+1)'(BUCKETS);
  assign scan_end = !scan_re && !pend_r;

  always_comb begin
    re    = 1'b0;
    raddr = scan_r[BKT_W-1:0];
    if (state_r == S_SPLIT || state_r == S_SWEEP) begin
      re = scan_re;
    end else if (state_r == S_LOOK) begin
      re    = 1'b1;
      raddr = bucket_c;
    end
  end

  // small flows, and with aging only those idle past the limit
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      ev[w] = valid_r[prow_r][w] && (row_rd[w].count < min_r) &&
              (!aging_r || elapsed_gt(t_time_r, row_rd[w].last_time, idle_r));
    end
  end

  ftwa_ram #(.WIDTH(ROW_W), .DEPTH(BUCKETS)) u_ram (
    .clk   (clk),
    .we    (state_r == S_CMP && mwr),
    .waddr (bucket_r),
    .wdata (ROW_W'(row_new)),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_data)
  );

  ftwa_match u_match (
    .row      (row_rd),
    .vld      (valid_r[bucket_r]),
    .src_addr (t_src_r),
    .dst_addr (t_dst_r),
    .ports    (t_ports_r),
    .protocol (t_proto_r),
    .now      (t_time_r),
    .res      (mres),
    .row_new  (row_new),
    .vld_new  (vld_new),
    .wr       (mwr)
  );

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.hit          = o_hit_r;
  assign out_ch.dropped      = o_drop_r;
  assign out_ch.bucket       = o_bucket_r;
  assign out_ch.way          = o_way_r;
  assign out_ch.flow_packets = o_pk_r;
  assign out_ch.new_trace    = o_new_r;
  assign out_ch.trace_number = o_trace_r;
  assign out_ch.swept        = o_swept_r;
  assign out_ch.removed      = o_rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      trace_gap_r <= 32'd3600;
      interval_r  <= 32'd1800;
      idle_r      <= 32'd300;
      min_r       <= 32'd100;
      prev_r      <= '0;
      anchor_r    <= '0;
      seen_r      <= 1'b0;
      trace_r     <= '0;
      valid_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_TRACE_GAP:      trace_gap_r <= cfg_data;
          REG_SWEEP_INTERVAL: interval_r  <= cfg_data;
          REG_IDLE_LIMIT:     idle_r      <= cfg_data;
          REG_MIN_PACKETS:    min_r       <= cfg_data;
          default: ;
        endcase
      end
      // the result state reloads the output register itself
      if (out_valid_r && out_ch.ready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            t_src_r   <= in_ch.src_addr;
            t_dst_r   <= in_ch.dst_addr;
            t_ports_r <= {in_ch.src_port, in_ch.dst_port};
            t_proto_r <= in_ch.protocol;
            t_time_r  <= in_ch.time_sec;
            removed_r <= '0;
            swept_r   <= 1'b0;
            prev_r    <= in_ch.time_sec;
            seen_r    <= 1'b1;
            if (!seen_r || elapsed_gt(in_ch.time_sec, prev_r, trace_gap_r)) begin
              new_trace_r <= 1'b1;
              trace_r     <= trace_r + 16'd1;
              anchor_r    <= in_ch.time_sec;
              aging_r     <= 1'b0;
              scan_r      <= '0;
              pend_r      <= 1'b0;
              state_r     <= S_SPLIT;
            end else begin
              new_trace_r <= 1'b0;
              state_r     <= S_LOOK;
            end
          end
        end
        S_SPLIT, S_SWEEP: begin
          pend_r <= scan_re;
          prow_r <= scan_r[BKT_W-1:0];
          if (scan_re) scan_r <= scan_r + 1'b1;
          if (pend_r) begin
            valid_r[prow_r] <= valid_r[prow_r] & ~ev;
            removed_r       <= removed_r + REM_W'($countones(ev));
          end
          if (scan_end) state_r <= (state_r == S_SPLIT) ? S_LOOK : S_DONE;
        end
        S_LOOK: begin
          bucket_r <= bucket_c;
          state_r  <= S_CMP;
        end
        S_CMP: begin
          valid_r[bucket_r] <= vld_new;
          res_r             <= mres;
          if (elapsed_gt(t_time_r, anchor_r, interval_r)) begin
            swept_r  <= 1'b1;
            anchor_r <= t_time_r;
            aging_r  <= 1'b1;
            scan_r   <= '0;
            pend_r   <= 1'b0;
            state_r  <= S_SWEEP;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            o_hit_r     <= res_r.hit;
            o_drop_r    <= res_r.dropped;
            o_bucket_r  <= 6'(bucket_r);
            o_way_r     <= 2'(res_r.way);
            o_pk_r      <= res_r.packets;
            o_new_r     <= new_trace_r;
            o_trace_r   <= trace_r;
            o_swept_r   <= swept_r;
            o_rem_r     <= (removed_r > REM_W'(REMOVED_MAX)) ? REMOVED_MAX
                                                              : removed_r[8:0];
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_accept_seq, in_ch.valid && in_ch.ready, state_r == S_SPLIT || state_r == S_LOOK, "accepted beat did not start split or lookup")
  `ASSERT_IMPL(a_hit_drop, state_r == S_CMP, !(mres.hit && mres.dropped), "hit and drop together")
  `ASSERT_IMPL(a_scan_exit, (state_r == S_SPLIT || state_r == S_SWEEP) && scan_end, scan_r == (BKT_W+1)'(BUCKETS), "sweep ended before last row")
endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the flow table with trace splitting and idle aging.
module tb;
  import ftwa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ENTRIES = BUCKETS * WAYS;
  localparam int DRAIN_CYCLES = 3 * (BUCKETS + 1) + 16;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam int POOL_SIZE = 24;

  typedef struct {
    bit [31:0] sa;
    bit [31:0] da;
    bit [15:0] sp;
    bit [15:0] dp;
    bit [7:0]  pr;
  } tuple_t;

  typedef struct {
    bit        hit;
    bit        dropped;
    bit [5:0]  bucket;
    bit [1:0]  way;
    bit [31:0] packets;
    bit        new_trace;
    bit [15:0] trace_number;
    bit        swept;
    bit [8:0]  removed;
  } lookup_res_t;

  // directed row: tuple, time, and optional hand-typed expectation
  typedef struct {
    tuple_t      tup;
    bit [31:0]   ts;
    bit          typed;
    lookup_res_t res;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_data;

  ftwa_in_if  in_ch();
  ftwa_out_if out_ch();

  flow_table_with_aging_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // predictor state
  bit [31:0] gap_reg, sweep_reg, idle_reg, minpk_reg;
  bit        tbl_valid [NUM_ENTRIES];
  bit [31:0] tbl_sa [NUM_ENTRIES];
  bit [31:0] tbl_da [NUM_ENTRIES];
  bit [31:0] tbl_ports [NUM_ENTRIES];
  bit [7:0]  tbl_pr [NUM_ENTRIES];
  bit [31:0] tbl_count [NUM_ENTRIES];
  bit [31:0] tbl_last [NUM_ENTRIES];
  bit [31:0] prev_ts, anchor_ts;
  bit        seen_pkt;
  bit [15:0] trace_cnt;

  lookup_res_t pending_lookups[$];
  int  in_beats, out_beats, errors;
  int  n_hits, n_drops, n_traces, n_sweeps;
  longint cycles;
  bit  quiet;
  bit  cur_typed;
  lookup_res_t cur_res;
  tuple_t pool [POOL_SIZE];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit [31:0] since(bit [31:0] now, bit [31:0] then);
    return (now > then) ? now - then : 32'd0;
  endfunction

  function automatic int age_out(bit aging, bit [31:0] now);
    int n;
    n = 0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (!tbl_valid[i] || tbl_count[i] >= minpk_reg) continue;
      if (aging && since(now, tbl_last[i]) <= idle_reg) continue;
      tbl_valid[i] = 1'b0;
      n++;
    end
    return n;
  endfunction

  function automatic lookup_res_t predict_lookup(tuple_t t, bit [31:0] now);
    lookup_res_t r;
    bit [63:0] h;
    bit [31:0] ports;
    int base, free_way, idx, gone;
    r = '{default: 0};
    gone = 0;
    free_way = -1;
    ports = {t.sp, t.dp};
    if (!seen_pkt || since(now, prev_ts) > gap_reg) begin
      r.new_trace = 1'b1;
      trace_cnt++;
      anchor_ts = now;
      gone += age_out(1'b0, now);
    end
    h = ({32'd0, t.sa} * 64'd59) ^ {32'd0, t.da} ^ ({48'd0, t.sp} << 16) ^
        {48'd0, t.dp} ^ {56'd0, t.pr};
    r.bucket = 6'(h % BUCKETS);
    base = r.bucket * WAYS;
    for (int w = 0; w < WAYS; w++) begin
      idx = base + w;
      if (!tbl_valid[idx]) begin
        if (free_way < 0) free_way = w;
        continue;
      end
      if (tbl_sa[idx] == t.sa && tbl_da[idx] == t.da && tbl_ports[idx] == ports &&
          tbl_pr[idx] == t.pr) begin
        r.hit = 1'b1;
        r.way = 2'(w);
        break;
      end
    end
    if (r.hit) begin
      idx = base + r.way;
      if (tbl_count[idx] != 32'hFFFF_FFFF) tbl_count[idx]++;
      tbl_last[idx] = now;
      r.packets = tbl_count[idx];
    end else if (free_way >= 0) begin
      r.way = 2'(free_way);
      idx = base + free_way;
      tbl_valid[idx] = 1'b1;
      tbl_sa[idx] = t.sa;
      tbl_da[idx] = t.da;
      tbl_ports[idx] = ports;
      tbl_pr[idx] = t.pr;
      tbl_count[idx] = 32'd1;
      tbl_last[idx] = now;
      r.packets = 32'd1;
    end else begin
      r.dropped = 1'b1;
    end
    if (since(now, anchor_ts) > sweep_reg) begin
      r.swept = 1'b1;
      anchor_ts = now;
      gone += age_out(1'b1, now);
    end
    prev_ts = now;
    seen_pkt = 1'b1;
    r.trace_number = trace_cnt;
    r.removed = (gone > 511) ? 9'd511 : gone[8:0];
    return r;
  endfunction

  function automatic void check_field(string name, longint exp_v, longint got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  // input beats feed the predictor, output beats are checked against it
  always @(posedge clk) begin
    lookup_res_t p, e;
    tuple_t t;
    if (rst_n) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("flow_table_with_aging_top regression: fail");
        $finish;
      end
      if (in_ch.valid && in_ch.ready) begin
        t = '{in_ch.src_addr, in_ch.dst_addr, in_ch.src_port, in_ch.dst_port,
              in_ch.protocol};
        p = predict_lookup(t, in_ch.time_sec);
        if (cur_typed) begin
          p.hit = cur_res.hit;
          p.dropped = cur_res.dropped;
          p.way = cur_res.way;
          p.packets = cur_res.packets;
          p.new_trace = cur_res.new_trace;
          p.trace_number = cur_res.trace_number;
        end
        pending_lookups.insert(pending_lookups.size(), p);
        in_beats++;
      end
      if (out_ch.valid && out_ch.ready) begin
        out_beats++;
        if (pending_lookups.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got bucket %0d",
                   $time, out_ch.bucket);
          errors++;
        end else begin
          e = pending_lookups.pop_front();
          check_field("hit", e.hit, out_ch.hit);
          check_field("dropped", e.dropped, out_ch.dropped);
          check_field("bucket", e.bucket, out_ch.bucket);
          check_field("way", e.way, out_ch.way);
          check_field("flow_packets", e.packets, out_ch.flow_packets);
          check_field("new_trace", e.new_trace, out_ch.new_trace);
          check_field("trace_number", e.trace_number, out_ch.trace_number);
          check_field("swept", e.swept, out_ch.swept);
          check_field("removed", e.removed, out_ch.removed);
          n_hits += e.hit;
          n_drops += e.dropped;
          n_traces += e.new_trace;
          n_sweeps += e.swept;
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    int stall, seen;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = quiet ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      seen = out_beats;
      while (out_beats == seen) @(negedge clk);
    end
  end

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_packet(tuple_t t, bit [31:0] ts, bit typed, lookup_res_t r);
    int gap, seen;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.src_addr = t.sa;
    in_ch.dst_addr = t.da;
    in_ch.src_port = t.sp;
    in_ch.dst_port = t.dp;
    in_ch.protocol = t.pr;
    in_ch.time_sec = ts;
    cur_typed = typed;
    cur_res = r;
    in_ch.valid = 1'b1;
    seen = in_beats;
    while (in_beats == seen) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, bit [31:0] val);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_TRACE_GAP:      gap_reg = val;
      REG_SWEEP_INTERVAL: sweep_reg = val;
      REG_IDLE_LIMIT:     idle_reg = val;
      default:            minpk_reg = val;
    endcase
  endtask

  task automatic drain();
    int n;
    in_ch.valid = 1'b0;
    n = 0;
    while ((pending_lookups.size() != 0 || in_beats != out_beats) && n < 200000) begin
      @(negedge clk);
      n++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic lookup_res_t typed_res(bit hit, bit drop, bit [1:0] way,
                                            bit [31:0] pk, bit nt, bit [15:0] tn);
    lookup_res_t r;
    r = '{default: 0};
    r.hit = hit;
    r.dropped = drop;
    r.way = way;
    r.packets = pk;
    r.new_trace = nt;
    r.trace_number = tn;
    return r;
  endfunction

  function automatic tuple_t rand_tuple();
    tuple_t t;
    t.sa = $urandom;
    t.da = $urandom;
    t.sp = $urandom;
    t.dp = $urandom;
    t.pr = $urandom;
    return t;
  endfunction

  task automatic run_phase(int items, bit [31:0] t0);
    bit [31:0] now;
    tuple_t t;
    lookup_res_t nr;
    int pick;
    nr = '{default: 0};
    now = t0;
    // half the pool shares one bucket so drops and way fill-up happen
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool[i] = rand_tuple();
      if (i < POOL_SIZE / 2) pool[i].sa = pool[0].sa + 32'(i * 64);
      if (i < POOL_SIZE / 2) begin
        pool[i].da = pool[0].da;
        pool[i].dp = pool[0].dp;
        pool[i].pr = pool[0].pr;
      end
    end
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) now += $urandom_range(0, 3);
      else if (pick < 85) now += $urandom_range(0, 400);
      else if (pick < 92) now += $urandom_range(1000, 2500);
      else if (pick < 97) now += $urandom_range(3000, 5000);
      else now -= $urandom_range(0, 100);
      if ($urandom_range(0, 9) < 8) t = pool[$urandom_range(0, POOL_SIZE - 1)];
      else t = rand_tuple();
      send_packet(t, now, 1'b0, nr);
    end
    drain();
  endtask

  initial begin
    dir_row_t rows[$];
    tuple_t z, ones, b0;
    lookup_res_t nr;
    nr = '{default: 0};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_TRACE_GAP;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.src_addr = '0;
    in_ch.dst_addr = '0;
    in_ch.src_port = '0;
    in_ch.dst_port = '0;
    in_ch.protocol = '0;
    in_ch.time_sec = '0;
    gap_reg = 3600;
    sweep_reg = 1800;
    idle_reg = 300;
    minpk_reg = 100;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    prev_ts = 0;
    anchor_ts = 0;
    seen_pkt = 0;
    trace_cnt = 0;
    quiet = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    z = '{default: 0};
    ones = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF};
    b0 = z;
    // first packet after reset opens trace one
    rows.insert(rows.size(), '{z, 32'd0, 1'b1, typed_res(0, 0, 0, 1, 1, 1)});
    rows.insert(rows.size(), '{z, 32'd0, 1'b1, typed_res(1, 0, 0, 2, 0, 1)});
    rows.insert(rows.size(), '{ones, 32'd5, 1'b0, nr});
    rows.insert(rows.size(), '{ones, 32'd5, 1'b0, nr});
    // fill one bucket: src_addr steps of 64 keep the bucket
    b0.sa = 64;
    rows.insert(rows.size(), '{b0, 32'd6, 1'b1, typed_res(0, 0, 1, 1, 0, 1)});
    b0.sa = 128;
    rows.insert(rows.size(), '{b0, 32'd6, 1'b1, typed_res(0, 0, 2, 1, 0, 1)});
    b0.sa = 192;
    rows.insert(rows.size(), '{b0, 32'd7, 1'b1, typed_res(0, 0, 3, 1, 0, 1)});
    b0.sa = 256;
    rows.insert(rows.size(), '{b0, 32'd7, 1'b1, typed_res(0, 1, 0, 0, 0, 1)});
    b0.sa = 64;
    rows.insert(rows.size(), '{b0, 32'd8, 1'b1, typed_res(1, 0, 1, 2, 0, 1)});
    // time going backwards
    rows.insert(rows.size(), '{z, 32'd2, 1'b0, nr});
    // sweep at a long gap under trace_gap, then an insert into the swept bucket with a second sweep
    rows.insert(rows.size(), '{ones, 32'd1900, 1'b0, nr});
    b0.sa = 320;
    rows.insert(rows.size(), '{b0, 32'd3800, 1'b0, nr});
    // trace split evicts small flows, which here are all flows
    rows.insert(rows.size(), '{z, 32'd9000, 1'b0, nr});
    rows.insert(rows.size(), '{ones, 32'd9001, 1'b0, nr});
    rows.insert(rows.size(), '{rand_tuple(), 32'hFFFF_FFF0, 1'b0, nr});
    rows.insert(rows.size(), '{ones, 32'hFFFF_FFFF, 1'b0, nr});
    rows.insert(rows.size(), '{z, 32'hFFFF_FFFF, 1'b0, nr});
    foreach (rows[i]) send_packet(rows[i].tup, rows[i].ts, rows[i].typed, rows[i].res);
    drain();

    run_phase(150, 32'd20000);
    write_reg(REG_TRACE_GAP, 32'd500);
    write_reg(REG_SWEEP_INTERVAL, 32'd100);
    write_reg(REG_IDLE_LIMIT, 32'd50);
    write_reg(REG_MIN_PACKETS, 32'd3);
    run_phase(150, $urandom);
    // no idling at all in this stretch
    quiet = 1'b1;
    write_reg(REG_TRACE_GAP, 32'd0);
    write_reg(REG_SWEEP_INTERVAL, 32'd0);
    write_reg(REG_IDLE_LIMIT, 32'd0);
    write_reg(REG_MIN_PACKETS, 32'd1);
    run_phase(120, $urandom);
    quiet = 1'b0;
    write_reg(REG_TRACE_GAP, 32'hFFFF_FFFF);
    write_reg(REG_SWEEP_INTERVAL, 32'hFFFF_FFFF);
    write_reg(REG_IDLE_LIMIT, 32'hFFFF_FFFF);
    write_reg(REG_MIN_PACKETS, 32'hFFFF_FFFF);
    run_phase(120, $urandom);
    // zero min_packets: nothing is ever evicted
    write_reg(REG_TRACE_GAP, 32'd200);
    write_reg(REG_SWEEP_INTERVAL, 32'd50);
    write_reg(REG_IDLE_LIMIT, 32'd0);
    write_reg(REG_MIN_PACKETS, 32'd0);
    run_phase(100, $urandom);
    write_reg(REG_TRACE_GAP, 32'd3600);
    write_reg(REG_SWEEP_INTERVAL, 32'd1800);
    write_reg(REG_IDLE_LIMIT, 32'd300);
    write_reg(REG_MIN_PACKETS, 32'd100);
    run_phase(100, $urandom);

    if (pending_lookups.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_lookups.size());
      errors++;
    end
    $display("covered %0d packets over six register settings: %0d hits, %0d drops",
             in_beats, n_hits, n_drops);
    $display("trace splits %0d, aging sweeps %0d, mismatches %0d",
             n_traces, n_sweeps, errors);
    if (errors == 0) begin
      $display("flow_table_with_aging_top regression: pass");
    end else begin
      $display("flow_table_with_aging_top regression: fail");
    end
    $finish;
  end
endmodule
